[hdl/sldmx_pkg.sv]
// Shared constants for the scan line channel demultiplexer.
`default_nettype none

package sldmx_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SAMPLES_PER_LINE = 3'd0;
    localparam logic [2:0] CFG_HEADER_BYTES     = 3'd1;
    localparam logic [2:0] CFG_CHAN3_SELECT     = 3'd2;
    localparam logic [2:0] CFG_SWITCH_ENABLE    = 3'd3;
    localparam logic [2:0] CFG_SWITCH_ROW       = 3'd4;
    localparam logic [2:0] CFG_LINE_LIMIT       = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [11:0] RST_SAMPLES_PER_LINE = 12'd2048;
    localparam logic [7:0]  RST_HEADER_BYTES     = 8'd182;
    localparam logic        RST_CHAN3_SELECT     = 1'b1;
    localparam logic        RST_SWITCH_ENABLE    = 1'b0;
    localparam logic [15:0] RST_SWITCH_ROW       = 16'd0;
    localparam logic [15:0] RST_LINE_LIMIT       = 16'hFFFF;

    // Word positions within one sample.
    localparam logic [2:0] POS_CH1   = 3'd0;
    localparam logic [2:0] POS_CH2   = 3'd1;
    localparam logic [2:0] POS_CH3   = 3'd2;
    localparam logic [2:0] POS_CH4   = 3'd3;
    localparam logic [2:0] POS_CH5   = 3'd4;
    localparam logic [2:0] WORDS_PER_SAMPLE = 3'd5;

    // Channel slot codes.
    localparam logic [2:0] SLOT_CH1 = 3'd0;
    localparam logic [2:0] SLOT_CH2 = 3'd1;
    localparam logic [2:0] SLOT_CH3A = 3'd2;
    localparam logic [2:0] SLOT_CH3B = 3'd3;
    localparam logic [2:0] SLOT_CH4 = 3'd4;
    localparam logic [2:0] SLOT_CH5 = 3'd5;
    localparam int CHANNEL_SLOTS = 6;

endpackage

`default_nettype wire

[hdl/scan_line_channel_demux_unit.sv]
// Top level of the scan line channel demultiplexer.
//
// The slave stream carries the raw instrument frame, one byte per word on
// s_tdata. Each scan line opens with a calibration header of header_bytes
// bytes, which is dropped. Then come samples_per_line samples of five
// big-endian 16-bit words each; every completed word leaves on the master
// stream with its channel slot, scan row and column, and m_tlast marks the
// last word of a line. Only one of the slots 3A and 3B is present, chosen by
// chan3_select and optionally swapped from switch_row onward.
// Once line_limit lines are done, further bytes are taken and dropped.
// The output is registered: a word shows on the master side in the cycle
// after its second byte is accepted. Throughput is one byte per cycle while
// s_tready is high, that is while the output register is empty or is being
// emptied, so a stalled receiver stops input only when a word is waiting;
// all counter updates for a byte are computed combinationally. Reset loads
// the configuration defaults, clears all counters and starts in the header
// of line zero. The user must write configuration through the plain write
// port while the stream is idle; the block itself does not enforce this.
`default_nettype none

module scan_line_channel_demux_unit
    import sldmx_pkg::*;
#(
    parameter int MAX_SAMPLES = 2048
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] frame_byte
    // Output stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [2:0] channel_slot, [18:3] sample_value,
                                        // [34:19] line_row, [45:35] line_column,
                                        // [47:46] zero
    output logic             m_tlast    // end_of_line
);

    localparam int COL_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    // Configuration registers.
    logic [11:0] samples_per_line_reg;
    logic [7:0]  header_bytes_reg;
    logic        chan3_select_reg;
    logic        switch_enable_reg;
    logic [15:0] switch_row_reg;
    logic [15:0] line_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_per_line_reg <= RST_SAMPLES_PER_LINE;
            header_bytes_reg     <= RST_HEADER_BYTES;
            chan3_select_reg     <= RST_CHAN3_SELECT;
            switch_enable_reg    <= RST_SWITCH_ENABLE;
            switch_row_reg       <= RST_SWITCH_ROW;
            line_limit_reg       <= RST_LINE_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SAMPLES_PER_LINE: samples_per_line_reg <= cfg_data[11:0];
                CFG_HEADER_BYTES:     header_bytes_reg     <= cfg_data[7:0];
                CFG_CHAN3_SELECT:     chan3_select_reg     <= cfg_data[0];
                CFG_SWITCH_ENABLE:    switch_enable_reg    <= cfg_data[0];
                CFG_SWITCH_ROW:       switch_row_reg       <= cfg_data;
                CFG_LINE_LIMIT:       line_limit_reg       <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Frame position state.
    logic             in_header_reg,    in_header_next;
    logic [7:0]       header_count_reg, header_count_next;
    logic             high_pending_reg, high_pending_next;
    logic [7:0]       high_byte_reg,    high_byte_next;
    logic [2:0]       slot_index_reg,   slot_index_next;
    logic [COL_W-1:0] column_reg,       column_next;
    logic [15:0]      row_reg,          row_next;

    // Output register.
    logic             out_valid_reg,    out_valid_next;
    logic [2:0]       out_slot_reg,     out_slot_next;
    logic [15:0]      out_value_reg,    out_value_next;
    logic [15:0]      out_row_reg,      out_row_next;
    logic [COL_W-1:0] out_col_reg,      out_col_next;
    logic             out_eol_reg,      out_eol_next;

    logic        s_accept;
    logic        m_accept;
    logic [12:0] eff_samples;
    logic [12:0] column_plus1;
    logic [7:0]  header_plus1;
    logic [2:0]  pos;
    logic        keep_3a;
    logic [2:0]  slot_code;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = out_valid_reg && m_tready;

    // Samples per line with zero read as one and saturated at MAX_SAMPLES.
    always_comb
    begin
        if (samples_per_line_reg == 12'd0)
            eff_samples = 13'd1;
        else if ({1'b0, samples_per_line_reg} > 13'(MAX_SAMPLES))
            eff_samples = 13'(MAX_SAMPLES);
        else
            eff_samples = {1'b0, samples_per_line_reg};
    end

    assign column_plus1 = 13'(column_reg) + 13'd1;
    assign header_plus1 = header_count_reg + 8'd1;
    assign pos          = (slot_index_reg >= WORDS_PER_SAMPLE) ? POS_CH1 : slot_index_reg;
    assign keep_3a      = chan3_select_reg ^ (switch_enable_reg && (row_reg >= switch_row_reg));

    always_comb
    begin
        case (pos)
            POS_CH2: slot_code = SLOT_CH2;
            POS_CH3: slot_code = keep_3a ? SLOT_CH3A : SLOT_CH3B;
            POS_CH4: slot_code = SLOT_CH4;
            POS_CH5: slot_code = SLOT_CH5;
            default: slot_code = SLOT_CH1;
        endcase
    end

    always_comb
    begin
        in_header_next    = in_header_reg;
        header_count_next = header_count_reg;
        high_pending_next = high_pending_reg;
        high_byte_next    = high_byte_reg;
        slot_index_next   = slot_index_reg;
        column_next       = column_reg;
        row_next          = row_reg;

        out_valid_next = m_accept ? 1'b0 : out_valid_reg;
        out_slot_next  = out_slot_reg;
        out_value_next = out_value_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_eol_next   = out_eol_reg;

        if (s_accept && (row_reg < line_limit_reg))
        begin
            if (in_header_reg && (header_count_reg < header_bytes_reg))
            begin
                // Still inside the calibration header: count and drop the byte.
                if (header_plus1 >= header_bytes_reg)
                begin
                    in_header_next    = 1'b0;
                    header_count_next = 8'd0;
                end
                else
                begin
                    header_count_next = header_plus1;
                end
            end
            else
            begin
                in_header_next    = 1'b0;
                header_count_next = 8'd0;
                if (!high_pending_reg)
                begin
                    high_byte_next    = s_tdata;
                    high_pending_next = 1'b1;
                end
                else
                begin
                    high_pending_next = 1'b0;
                    out_valid_next    = 1'b1;
                    out_slot_next     = slot_code;
                    out_value_next    = {high_byte_reg, s_tdata};
                    out_row_next      = row_reg;
                    out_col_next      = column_reg;
                    out_eol_next      = 1'b0;
                    if (pos == POS_CH5)
                    begin
                        slot_index_next = POS_CH1;
                        if (column_plus1 >= eff_samples)
                        begin
                            out_eol_next      = 1'b1;
                            column_next       = '0;
                            row_next          = row_reg + 16'd1;
                            in_header_next    = 1'b1;
                            header_count_next = 8'd0;
                        end
                        else
                        begin
                            column_next = column_plus1[COL_W-1:0];
                        end
                    end
                    else
                    begin
                        slot_index_next = pos + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg    <= 1'b1;
            header_count_reg <= 8'd0;
            high_pending_reg <= 1'b0;
            high_byte_reg    <= 8'd0;
            slot_index_reg   <= POS_CH1;
            column_reg       <= '0;
            row_reg          <= 16'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            in_header_reg    <= in_header_next;
            header_count_reg <= header_count_next;
            high_pending_reg <= high_pending_next;
            high_byte_reg    <= high_byte_next;
            slot_index_reg   <= slot_index_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload of the output register needs no reset.
    always_ff @(posedge clk)
    begin
        out_slot_reg  <= out_slot_next;
        out_value_reg <= out_value_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_eol_reg   <= out_eol_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_eol_reg;
    assign m_tdata  = {2'b00, 11'(out_col_reg), out_row_reg, out_value_reg, out_slot_reg};

    // The last word of a line is always the fifth word of a sample.
    a_eol_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[2:0] == SLOT_CH5))
        else $error("end of line flagged on a word that is not the last of a sample");

    // The word position inside a sample stays in range.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_index_reg < WORDS_PER_SAMPLE)
        else $error("word position left its range");

    // Once the line limit is reached the row counter no longer moves.
    a_limit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg >= line_limit_reg && !cfg_wr_en) |=> $stable(row_reg))
        else $error("row counter moved past the line limit");

    // A byte taken once the line limit is reached emits no word.
    a_row_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && row_reg >= line_limit_reg && !m_accept && !out_valid_reg)
            |=> !m_tvalid)
        else $error("word emitted after the line limit");

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the scan line channel demultiplexer.
module testbench;
    import sldmx_pkg::*;

    localparam int SAMPLE_CAP   = 2048;
    localparam int RANDOM_BYTES = 650;
    localparam int IDLE_PERCENT = 31;
    localparam int CYCLE_LIMIT  = 600000;

    // Kinds of rows in the directed table.
    localparam logic ROW_BYTE = 1'b0;
    localparam logic ROW_CFG  = 1'b1;

    // One output word, split into its fields.
    typedef struct packed {
        logic [2:0]  slot;
        logic [15:0] value;
        logic [15:0] row;
        logic [10:0] column;
        logic        last;
    } word_rec_t;

    // One row of the directed table: either a register write or a byte. A byte
    // row may carry a hand-written word that it must produce.
    typedef struct packed {
        logic        kind;
        logic [2:0]  index;
        logic [15:0] data;
        logic        typed;
        word_rec_t   want;
    } stim_row_t;

    localparam word_rec_t NO_WORD = '0;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;
    logic        m_tlast;

    scan_line_channel_demux_unit #(
        .MAX_SAMPLES(SAMPLE_CAP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    logic [11:0] cur_samples;
    logic [7:0]  cur_header;
    logic        cur_c3_select;
    logic        cur_switch_en;
    logic [15:0] cur_switch_row;
    logic [15:0] cur_line_limit;

    // Shadow copy of the line parser state.
    logic        hdr_active;
    logic [7:0]  hdr_seen;
    logic        hi_waiting;
    logic [7:0]  hi_byte;
    logic [2:0]  word_pos;
    logic [10:0] col_count;
    logic [15:0] row_count;

    word_rec_t pending_words[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    bit        steady_flow    = 1'b0;

    // Directed part. The first sample after reset has its words written out by
    // hand; everything after it is checked against the line parser model.
    stim_row_t directed_rows [32] = '{
        // A zero sample count acts as one sample per line; no header at all.
        '{ROW_CFG,  CFG_SAMPLES_PER_LINE, 16'd0,   1'b0, NO_WORD},
        '{ROW_CFG,  CFG_HEADER_BYTES,     16'd0,   1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0000, 1'b1, '{SLOT_CH1,  16'h0000, 16'd0, 11'd0, 1'b0}},
        '{ROW_BYTE, 3'd0, 16'h00FF, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h00FF, 1'b1, '{SLOT_CH2,  16'hFFFF, 16'd0, 11'd0, 1'b0}},
        '{ROW_BYTE, 3'd0, 16'h0080, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0001, 1'b1, '{SLOT_CH3A, 16'h8001, 16'd0, 11'd0, 1'b0}},
        '{ROW_BYTE, 3'd0, 16'h0012, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0034, 1'b1, '{SLOT_CH4,  16'h1234, 16'd0, 11'd0, 1'b0}},
        '{ROW_BYTE, 3'd0, 16'h00A5, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h005A, 1'b1, '{SLOT_CH5,  16'hA55A, 16'd0, 11'd0, 1'b1}},
        // Two header bytes of four, then the header is cut short to one.
        '{ROW_CFG,  CFG_HEADER_BYTES,     16'd4,   1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0011, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0022, 1'b0, NO_WORD},
        '{ROW_CFG,  CFG_HEADER_BYTES,     16'd1,   1'b0, NO_WORD},
        // Line one keeps 3B; the swap only starts at line two.
        '{ROW_CFG,  CFG_CHAN3_SELECT,     16'd0,   1'b0, NO_WORD},
        '{ROW_CFG,  CFG_SWITCH_ENABLE,    16'd1,   1'b0, NO_WORD},
        '{ROW_CFG,  CFG_SWITCH_ROW,       16'd2,   1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0001, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0002, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h007F, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h00FE, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h00C3, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h003C, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0055, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h00AA, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h000F, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h00F0, 1'b0, NO_WORD},
        // Two lines are done, so the line limit drops everything that follows.
        '{ROW_CFG,  CFG_LINE_LIMIT,       16'd2,   1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0099, 1'b0, NO_WORD},
        '{ROW_BYTE, 3'd0, 16'h0066, 1'b0, NO_WORD}
    };

    function automatic void reset_model();
        cur_samples    = RST_SAMPLES_PER_LINE;
        cur_header     = RST_HEADER_BYTES;
        cur_c3_select  = RST_CHAN3_SELECT;
        cur_switch_en  = RST_SWITCH_ENABLE;
        cur_switch_row = RST_SWITCH_ROW;
        cur_line_limit = RST_LINE_LIMIT;
        hdr_active     = 1'b1;
        hdr_seen       = '0;
        hi_waiting     = 1'b0;
        hi_byte        = '0;
        word_pos       = POS_CH1;
        col_count      = '0;
        row_count      = '0;
    endfunction

    // Advances the line parser by one byte; returns 1 when the byte completes
    // a word, which is then handed back in w.
    function automatic bit demux_byte(input logic [7:0] b, output word_rec_t w);
        int   line_len;
        logic keep_3a;
        logic [2:0] pos;
        w = '0;
        if (row_count >= cur_line_limit)
            return 1'b0;
        if (hdr_active)
        begin
            if (hdr_seen < cur_header)
            begin
                hdr_seen = hdr_seen + 8'd1;
                if (hdr_seen >= cur_header)
                begin
                    hdr_active = 1'b0;
                    hdr_seen   = '0;
                end
                return 1'b0;
            end
            // The header length is zero or no more than what has already been skipped.
            hdr_active = 1'b0;
            hdr_seen   = '0;
        end
        if (!hi_waiting)
        begin
            hi_byte    = b;
            hi_waiting = 1'b1;
            return 1'b0;
        end
        hi_waiting = 1'b0;
        pos = (word_pos >= WORDS_PER_SAMPLE) ? POS_CH1 : word_pos;
        keep_3a = cur_c3_select;
        if (cur_switch_en && row_count >= cur_switch_row)
            keep_3a = !keep_3a;
        case (pos)
            POS_CH2: w.slot = SLOT_CH2;
            POS_CH3: w.slot = keep_3a ? SLOT_CH3A : SLOT_CH3B;
            POS_CH4: w.slot = SLOT_CH4;
            POS_CH5: w.slot = SLOT_CH5;
            default: w.slot = SLOT_CH1;
        endcase
        w.value  = {hi_byte, b};
        w.row    = row_count;
        w.column = col_count;
        if (pos == POS_CH5)
        begin
            word_pos = POS_CH1;
            line_len = int'(cur_samples);
            if (line_len == 0)
                line_len = 1;
            if (line_len > SAMPLE_CAP)
                line_len = SAMPLE_CAP;
            if (int'(col_count) + 1 >= line_len)
            begin
                w.last     = 1'b1;
                col_count  = '0;
                row_count  = row_count + 16'd1;
                hdr_active = 1'b1;
                hdr_seen   = '0;
            end
            else
                col_count = col_count + 11'd1;
        end
        else
            word_pos = pos + 3'd1;
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SAMPLES_PER_LINE: cur_samples    = val[11:0];
            CFG_HEADER_BYTES:     cur_header     = val[7:0];
            CFG_CHAN3_SELECT:     cur_c3_select  = val[0];
            CFG_SWITCH_ENABLE:    cur_switch_en  = val[0];
            CFG_SWITCH_ROW:       cur_switch_row = val;
            CFG_LINE_LIMIT:       cur_line_limit = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Stops the input and waits until every predicted word has come out, then
    // keeps waiting in case a byte without a word is still in the pipeline.
    task automatic drain_words();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Offers one byte, after a random gap unless the flow is steady, and waits
    // until it is taken. Valid stays high on return for back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input bit use_typed,
                             input word_rec_t typed_word, output bit ignored);
        word_rec_t w;
        bit        got;
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ignored = (row_count >= cur_line_limit);
        got = demux_byte(b, w);
        if (got)
            pending_words.push_back(use_typed ? typed_word : w);
    endtask

    // The receiver stalls at random, except during the steady stretch.
    always @(posedge clk)
        m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Every word taken from the master side is compared with the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin : word_checker
        word_rec_t seen;
        word_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.slot   = m_tdata[2:0];
            seen.value  = m_tdata[18:3];
            seen.row    = m_tdata[34:19];
            seen.column = m_tdata[45:35];
            seen.last   = m_tlast;
            if (pending_words.size() == 0)
            begin
                $display("%0t: word with no prediction, expected none, got %h last %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (seen.slot !== want.slot)
                begin
                    $display("%0t: channel_slot expected %0d, got %0d",
                             $time, want.slot, seen.slot);
                    mismatch_count++;
                end
                if (seen.value !== want.value)
                begin
                    $display("%0t: sample_value expected %h, got %h",
                             $time, want.value, seen.value);
                    mismatch_count++;
                end
                if (seen.row !== want.row)
                begin
                    $display("%0t: line_row expected %0d, got %0d",
                             $time, want.row, seen.row);
                    mismatch_count++;
                end
                if (seen.column !== want.column)
                begin
                    $display("%0t: line_column expected %0d, got %0d",
                             $time, want.column, seen.column);
                    mismatch_count++;
                end
                if (seen.last !== want.last)
                begin
                    $display("%0t: end_of_line expected %b, got %b",
                             $time, want.last, seen.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        bit          ignored;
        int          fed;
        int          phase;
        bit          wide_done;
        logic [15:0] val;
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain_words();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
                send_byte(directed_rows[i].data[7:0], directed_rows[i].typed,
                          directed_rows[i].want, ignored);
        end

        // Random phases. Each starts from an idle block and writes new register
        // values; phases end at random points, so register changes land in the
        // middle of headers, samples and lines.
        fed = 0;
        phase = 0;
        wide_done = 1'b0;
        while (fed < RANDOM_BYTES)
        begin
            drain_words();
            steady_flow = (phase >= 6 && phase < 12);
            if (!wide_done && fed >= RANDOM_BYTES / 2)
            begin
                // Part of a line at the largest count, which saturates to the
                // sample cap; the next register set lowers the count mid-line.
                write_reg(CFG_SAMPLES_PER_LINE, 16'h0FFF);
                write_reg(CFG_HEADER_BYTES, 16'd0);
                write_reg(CFG_LINE_LIMIT, 16'hFFFF);
                repeat (60)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD, ignored);
                    if (!ignored)
                        fed++;
                end
                wide_done = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: val = 16'd0;
                    1: val = 16'd1;
                    9: val = 16'($urandom_range(7, 24));
                    default: val = 16'($urandom_range(2, 6));
                endcase
                write_reg(CFG_SAMPLES_PER_LINE, val);
                case ($urandom_range(0, 11))
                    0: val = 16'd0;
                    11: val = 16'd255;
                    default: val = 16'($urandom_range(1, 8));
                endcase
                write_reg(CFG_HEADER_BYTES, val);
                write_reg(CFG_CHAN3_SELECT, 16'($urandom_range(0, 1)));
                write_reg(CFG_SWITCH_ENABLE, 16'($urandom_range(0, 1)));
                case ($urandom_range(0, 5))
                    0: val = 16'd0;
                    1: val = 16'hFFFF;
                    default: val = row_count + 16'($urandom_range(0, 3));
                endcase
                write_reg(CFG_SWITCH_ROW, val);
                case ($urandom_range(0, 7))
                    0: val = 16'd0;
                    1: val = row_count + 16'($urandom_range(0, 2));
                    2: val = 16'hFFFF;
                    default: val = row_count + 16'($urandom_range(3, 30));
                endcase
                write_reg(CFG_LINE_LIMIT, val);
                repeat ($urandom_range(4, 50))
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD, ignored);
                    if (!ignored)
                        fed++;
                end
            end
            phase++;
        end

        drain_words();
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
